>>> hw/rtl/tpd_pkg.sv
// Shared definitions for the typed packet deframer: type codes, packet
// lengths and the parser mode type.
// No dependencies.
package tpd_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned IndexW = 12;

   // Packet type codes
   localparam logic [ByteW-1:0] TypePong  = 8'h81;
   localparam logic [ByteW-1:0] TypeState = 8'h82;
   localparam logic [ByteW-1:0] TypeTelem = 8'h83;
   localparam logic [ByteW-1:0] TypeShot  = 8'h84;

   // Payload lengths in bytes
   localparam logic [IndexW-1:0] LenState   = 12'd5;
   localparam logic [IndexW-1:0] LenTelem   = 12'd24;
   localparam logic [IndexW-1:0] LenShotHdr = 12'd5;

   // Parser mode
   typedef enum logic [1:0] {
      ModeIdle    = 2'd0,
      ModePayload = 2'd1,
      ModeStages  = 2'd2
   } mode_type;

   // Total shot packet length: header plus count stages of 12 bytes each
   function automatic logic [IndexW-1:0] shot_length(input logic [ByteW-1:0] count);
      logic [IndexW-1:0] c;
      c = {{(IndexW-ByteW){1'b0}}, count};
      return LenShotHdr + (c << 3) + (c << 2);
   endfunction

endpackage

>>> hw/rtl/typed_packet_deframer.sv
// Typed packet deframer: parses a byte stream into typed packets and streams
// each payload byte with its type, offset and end marker.
// Depends on tpd_pkg.
//
// An accepted byte that yields a result reaches rsp_ in the next cycle.
// Throughput: one byte per cycle; the single output register is refilled in
// the same cycle its result transfers, so stalls only when rsp_stall holds.
// Reset: synchronous, active high; parser returns to waiting for a type byte
// and the output register empties.
module typed_packet_deframer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tpd_pkg::ByteW-1:0]     req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tpd_pkg::ByteW-1:0]     rsp_packet_type,
   output logic                          rsp_has_byte,
   output logic [tpd_pkg::ByteW-1:0]     rsp_payload_byte,
   output logic [tpd_pkg::IndexW-1:0]    rsp_byte_index,
   output logic                          rsp_last
);

   tpd_pkg::mode_type                  mode_ff, mode_in;
   logic [tpd_pkg::ByteW-1:0]          type_ff, type_in;
   logic [tpd_pkg::IndexW-1:0]         seen_ff, seen_in;
   logic [tpd_pkg::IndexW-1:0]         expected_ff, expected_in;

   logic                               valid_ff, valid_in;
   logic [tpd_pkg::ByteW-1:0]          out_type_ff, out_type_in;
   logic                               out_has_ff, out_has_in;
   logic [tpd_pkg::ByteW-1:0]          out_byte_ff, out_byte_in;
   logic [tpd_pkg::IndexW-1:0]         out_index_ff, out_index_in;
   logic                               out_last_ff, out_last_in;

   logic                               take;
   logic                               emit;
   logic [tpd_pkg::IndexW-1:0]         seen_next;

   // Input is held only while a result waits and the consumer stalls
   assign req_stall = valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;
   assign seen_next = seen_ff + 1'b1;

   // Parser next state and result
   always_comb begin
      mode_in      = mode_ff;
      type_in      = type_ff;
      seen_in      = seen_ff;
      expected_in  = expected_ff;
      emit         = 1'b0;
      out_type_in  = type_ff;
      out_has_in   = 1'b1;
      out_byte_in  = req_rx_byte;
      out_index_in = seen_ff;
      out_last_in  = 1'b0;
      if (take) begin
         if (mode_ff == tpd_pkg::ModePayload || mode_ff == tpd_pkg::ModeStages) begin
            // payload byte
            emit    = 1'b1;
            seen_in = seen_next;
            if (seen_next >= expected_ff) begin
               if (mode_ff == tpd_pkg::ModePayload && type_ff == tpd_pkg::TypeShot
                   && req_rx_byte != '0) begin
                  // stage count byte extends the shot packet
                  expected_in = tpd_pkg::shot_length(req_rx_byte);
                  mode_in     = tpd_pkg::ModeStages;
               end else begin
                  out_last_in = 1'b1;
                  mode_in     = tpd_pkg::ModeIdle;
               end
            end
         end else begin
            // type byte; unknown codes leave the parser idle
            mode_in = tpd_pkg::ModeIdle;
            type_in = req_rx_byte;
            seen_in = '0;
            case (req_rx_byte)
               tpd_pkg::TypePong: begin
                  emit         = 1'b1;
                  out_type_in  = req_rx_byte;
                  out_has_in   = 1'b0;
                  out_byte_in  = '0;
                  out_index_in = '0;
                  out_last_in  = 1'b1;
               end
               tpd_pkg::TypeState: begin
                  expected_in = tpd_pkg::LenState;
                  mode_in     = tpd_pkg::ModePayload;
               end
               tpd_pkg::TypeTelem: begin
                  expected_in = tpd_pkg::LenTelem;
                  mode_in     = tpd_pkg::ModePayload;
               end
               tpd_pkg::TypeShot: begin
                  expected_in = tpd_pkg::LenShotHdr;
                  mode_in     = tpd_pkg::ModePayload;
               end
               default: begin
                  mode_in = tpd_pkg::ModeIdle;
               end
            endcase
         end
      end
   end

   // Output register occupancy
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = emit;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= tpd_pkg::ModeIdle;
         type_ff     <= '0;
         seen_ff     <= '0;
         expected_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         type_ff     <= type_in;
         seen_ff     <= seen_in;
         expected_ff <= expected_in;
         valid_ff    <= valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (take && emit) begin
         out_type_ff  <= out_type_in;
         out_has_ff   <= out_has_in;
         out_byte_ff  <= out_byte_in;
         out_index_ff <= out_index_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_packet_type  = out_type_ff;
   assign rsp_has_byte     = out_has_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_byte_index   = out_index_ff;
   assign rsp_last         = out_last_ff;

   // An empty result is always the complete pong packet
   a_empty_is_pong: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_has_ff) |->
         (out_last_ff && out_type_ff == tpd_pkg::TypePong && out_index_ff == '0))
      else $error("empty result is not a pong packet");

   // A result that ends a packet leaves the parser waiting for a type byte
   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      (take && emit && out_last_in) |=> (mode_ff == tpd_pkg::ModeIdle))
      else $error("parser not idle after last byte");

   // A type byte never yields a payload result
   a_type_no_payload: assert property (@(posedge clock) disable iff (reset)
      (take && mode_ff == tpd_pkg::ModeIdle && req_rx_byte != tpd_pkg::TypePong)
         |=> !valid_ff)
      else $error("result produced for a type byte");

   // While parsing a packet the offset stays below the expected length
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == tpd_pkg::ModePayload || mode_ff == tpd_pkg::ModeStages)
         |-> (seen_ff < expected_ff))
      else $error("byte offset beyond packet length");

endmodule
